@@ hdl/pcg64_pkg.sv @@
// Shared types, constants and functions for the PCG64 XSL-RR generator.
package pcg64_pkg;

    localparam logic [127:0] LCG_MULT = {64'd2549297995355413924, 64'd4865540595714422341};
    localparam logic [31:0] SS_INIT_A = 32'h43b0d7e5;
    localparam logic [31:0] SS_MULT_A = 32'h931e8875;
    localparam logic [31:0] SS_INIT_B = 32'h8b51f9dd;
    localparam logic [31:0] SS_MULT_B = 32'h58f38ded;
    localparam logic [31:0] SS_MIX_L  = 32'hca01f9dd;
    localparam logic [31:0] SS_MIX_R  = 32'h4973f715;
    localparam int unsigned SS_SHIFT  = 16;
    localparam int unsigned ROT_SHIFT = 58;

    localparam logic [1:0] REQ_DRAW    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_RESEED  = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] jump_hi;
        logic [63:0] jump_lo;
    } pcg_in_t;

    typedef struct packed {
        logic [63:0] rand_value;
        logic        is_draw;
    } pcg_out_t;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MS_STEP,   // state * MULT
        MS_AM,     // am * cm
        MS_AP,     // ap * cm
        MS_CP,     // (cm+1) * cp
        MS_CM,     // cm * cm
        MS_FINAL   // am * state
    } msel_t;

    // datapath ops
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_START,  // launch 128x128 mult
        OP_STEP_DONE,  // state = prod + inc
        OP_ADV_INIT,
        OP_AM_DONE,
        OP_AP_DONE,    // ap = prod + cp
        OP_CP_DONE,
        OP_CM_DONE,    // cm = prod, shift delta
        OP_FINAL_DONE, // state = prod + ap
        OP_SEED_INIT,
        OP_HASH,       // one hash sequencer phase
        OP_ADD_INIT    // state += init_state
    } op_t;

    typedef struct packed {
        op_t         op;
        msel_t       msel;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic delta_zero;
        logic delta_bit;
        logic hash_done;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_MUL,
        ST_STEP_WAIT,
        ST_ADV_TEST,
        ST_ADV_MUL,
        ST_ADV_WAIT,
        ST_FIN_MUL,
        ST_FIN_WAIT,
        ST_HASH,
        ST_SEED_MUL,
        ST_SEED_WAIT,
        ST_OUT
    } state_t;

    function automatic logic [31:0] mix2(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] r;
        r = (SS_MIX_L * x) - (SS_MIX_R * y);
        return r ^ (r >> SS_SHIFT);
    endfunction

    function automatic logic [63:0] xsl_rr(input logic [127:0] s);
        logic [63:0]  v;
        logic [5:0]   rot;
        logic [127:0] dbl;
        v   = s[127:64] ^ s[63:0];
        rot = s[127:122];
        dbl = {v, v} >> rot;
        return dbl[63:0];
    endfunction

endpackage

@@ hdl/pcg64_mul.sv @@
// 128x128 low-half multiplier, one 32x32 partial product per cycle.
module pcg64_mul
    import pcg64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] a,
    input  logic [127:0] b,
    output logic [127:0] prod,
    output logic         done
);
    logic [127:0] a_reg, a_next;
    logic [127:0] b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [1:0]   ai, bi;
    logic [2:0]   sh;
    logic [63:0]  pp;
    logic [127:0] term;

    // only word pairs with ai + bi < 4 reach the low 128 bits
    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    begin bi = 2'd0; ai = 2'd0; end
            4'd1:    begin bi = 2'd0; ai = 2'd1; end
            4'd2:    begin bi = 2'd0; ai = 2'd2; end
            4'd3:    begin bi = 2'd0; ai = 2'd3; end
            4'd4:    begin bi = 2'd1; ai = 2'd0; end
            4'd5:    begin bi = 2'd1; ai = 2'd1; end
            4'd6:    begin bi = 2'd1; ai = 2'd2; end
            4'd7:    begin bi = 2'd2; ai = 2'd0; end
            4'd8:    begin bi = 2'd2; ai = 2'd1; end
            4'd9:    begin bi = 2'd3; ai = 2'd0; end
            default: begin bi = 2'd0; ai = 2'd0; end
        endcase
        pp   = a_reg[{ai, 5'd0} +: 32] * b_reg[{bi, 5'd0} +: 32];
        sh   = {1'b0, ai} + {1'b0, bi};
        term = {64'd0, pp} << {sh, 5'd0};
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + term;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd9)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

@@ hdl/pcg64_dp.sv @@
// Datapath: LCG state, increment, advance walk registers and seed hash sequencer.
module pcg64_dp
    import pcg64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  pcg_in_t     in_item,
    input  logic [63:0] seed,
    output dp_stat_t    stat,
    output logic [63:0] draw_value
);
    logic [127:0] state_reg, state_next;
    logic [127:0] inc_reg, inc_next;
    logic [127:0] am_reg, am_next, ap_reg, ap_next;
    logic [127:0] cm_reg, cm_next, cp_reg, cp_next;
    logic [127:0] d_reg, d_next;
    logic [127:0] init_reg, init_next;
    logic [31:0]  pool_reg [4];
    logic [31:0]  pool_next [4];
    logic [31:0]  hc_reg, hc_next;
    logic [31:0]  tmp_reg, tmp_next;
    logic [255:0] w_reg, w_next;
    logic [4:0]   hs_reg, hs_next;
    logic [1:0]   hph_reg, hph_next;
    logic [127:0] ma, mb, prod;
    logic         mul_done;
    logic [1:0]   src, dst;
    logic [31:0]  hv, hm;
    logic [2:0]   oi;

    always_comb
    begin
        unique case (cmd.msel)
            MS_STEP:  begin ma = state_reg; mb = LCG_MULT; end
            MS_AM:    begin ma = am_reg; mb = cm_reg; end
            MS_AP:    begin ma = ap_reg; mb = cm_reg; end
            MS_CP:    begin ma = cm_reg + 128'd1; mb = cp_reg; end
            MS_CM:    begin ma = cm_reg; mb = cm_reg; end
            MS_FINAL: begin ma = am_reg; mb = state_reg; end
            default:  begin ma = state_reg; mb = LCG_MULT; end
        endcase
    end

    pcg64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_MUL_START),
        .a     (ma),
        .b     (mb),
        .prod  (prod),
        .done  (mul_done)
    );

    // hash sequencer: hs 0..3 entropy, 4..15 mix pairs, 16..23 output words.
    // Each step runs in phases: 0 xor/hc update, 1 multiply, 2 finish.
    always_comb
    begin
        unique case (hs_reg)
            5'd4:    begin src = 2'd0; dst = 2'd1; end
            5'd5:    begin src = 2'd0; dst = 2'd2; end
            5'd6:    begin src = 2'd0; dst = 2'd3; end
            5'd7:    begin src = 2'd1; dst = 2'd0; end
            5'd8:    begin src = 2'd1; dst = 2'd2; end
            5'd9:    begin src = 2'd1; dst = 2'd3; end
            5'd10:   begin src = 2'd2; dst = 2'd0; end
            5'd11:   begin src = 2'd2; dst = 2'd1; end
            5'd12:   begin src = 2'd2; dst = 2'd3; end
            5'd13:   begin src = 2'd3; dst = 2'd0; end
            5'd14:   begin src = 2'd3; dst = 2'd1; end
            5'd15:   begin src = 2'd3; dst = 2'd2; end
            default: begin src = 2'd0; dst = 2'd0; end
        endcase
        oi = hs_reg[2:0];
        if (hs_reg < 5'd4)
            hv = (hs_reg < 5'd2) ? (hs_reg[0] ? seed[63:32] : seed[31:0]) : 32'd0;
        else if (hs_reg < 5'd16)
            hv = pool_reg[src];
        else
            hv = pool_reg[oi[1:0]];
        hm = tmp_reg * hc_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        inc_next   = inc_reg;
        am_next    = am_reg;
        ap_next    = ap_reg;
        cm_next    = cm_reg;
        cp_next    = cp_reg;
        d_next     = d_reg;
        init_next  = init_reg;
        pool_next  = pool_reg;
        hc_next    = hc_reg;
        tmp_next   = tmp_reg;
        w_next     = w_reg;
        hs_next    = hs_reg;
        hph_next   = hph_reg;
        unique case (cmd.op)
            OP_STEP_DONE:  state_next = prod + inc_reg;
            OP_ADV_INIT:
            begin
                am_next = 128'd1;
                ap_next = '0;
                cm_next = LCG_MULT;
                cp_next = inc_reg;
                d_next  = {in_item.jump_hi, in_item.jump_lo};
            end
            OP_AM_DONE:    am_next = prod;
            OP_AP_DONE:    ap_next = prod + cp_reg;
            OP_CP_DONE:    cp_next = prod;
            OP_CM_DONE:
            begin
                cm_next = prod;
                d_next  = d_reg >> 1;
            end
            OP_FINAL_DONE: state_next = prod + ap_reg;
            OP_SEED_INIT:
            begin
                hc_next  = SS_INIT_A;
                hs_next  = '0;
                hph_next = '0;
            end
            OP_HASH:
            begin
                unique case (hph_reg)
                    2'd0:
                    begin
                        tmp_next = hv ^ hc_reg;
                        hc_next  = hc_reg * ((hs_reg < 5'd16) ? SS_MULT_A : SS_MULT_B);
                        hph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        tmp_next = hm ^ (hm >> SS_SHIFT);
                        hph_next = 2'd2;
                    end
                    default:
                    begin
                        hph_next = 2'd0;
                        hs_next  = hs_reg + 5'd1;
                        if (hs_reg < 5'd4)
                            pool_next[hs_reg[1:0]] = tmp_reg;
                        else if (hs_reg < 5'd16)
                            pool_next[dst] = mix2(pool_reg[dst], tmp_reg);
                        else
                            w_next[oi*32 +: 32] = tmp_reg;
                        if (hs_reg == 5'd15)
                            hc_next = SS_INIT_B;
                        if (hs_reg == 5'd23)
                        begin
                            init_next  = {w_next[63:0], w_next[127:64]};
                            inc_next   = {w_next[190:128], w_next[255:192], 1'b1};
                            state_next = '0;
                        end
                    end
                endcase
            end
            OP_ADD_INIT:   state_next = state_reg + init_reg;
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            inc_reg   <= 128'd1;
            hs_reg    <= '0;
            hph_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            inc_reg   <= inc_next;
            hs_reg    <= hs_next;
            hph_reg   <= hph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        am_reg   <= am_next;
        ap_reg   <= ap_next;
        cm_reg   <= cm_next;
        cp_reg   <= cp_next;
        d_reg    <= d_next;
        init_reg <= init_next;
        pool_reg <= pool_next;
        hc_reg   <= hc_next;
        tmp_reg  <= tmp_next;
        w_reg    <= w_next;
    end

    assign stat.mul_done   = mul_done;
    assign stat.delta_zero = (d_reg == '0);
    assign stat.delta_bit  = d_reg[0];
    assign stat.hash_done  = (hs_reg == 5'd23) && (hph_reg == 2'd2);
    assign draw_value      = xsl_rr(state_reg);
endmodule

@@ hdl/pcg64_ctrl.sv @@
// Controller: request sequencing for draw, advance and reseed.
module pcg64_ctrl
    import pcg64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  req,
    input  logic        out_stall,
    input  dp_stat_t    stat,
    output logic        in_stall,
    output logic        out_valid,
    output logic        out_draw,
    output dp_cmd_t     cmd
);
    state_t     st_reg, st_next;
    logic [1:0] req_reg, req_next;
    logic [2:0] am_reg, am_next;   // advance sub-step 0 am,1 ap,2 cp,3 cm
    logic       seed2_reg, seed2_next;
    logic       vld_reg, vld_next;
    logic       drw_reg, drw_next;

    always_comb
    begin
        st_next    = st_reg;
        req_next   = req_reg;
        am_next    = am_reg;
        seed2_next = seed2_reg;
        vld_next   = vld_reg;
        drw_next   = drw_reg;
        cmd.op     = OP_NONE;
        cmd.msel   = MS_STEP;
        if (vld_reg && !out_stall)
            vld_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            if (in_valid && !(vld_reg && out_stall))
            begin
                req_next = req;
                unique case (req)
                    REQ_DRAW:    begin cmd.op = OP_MUL_START; st_next = ST_STEP_WAIT; end
                    REQ_ADVANCE: begin cmd.op = OP_ADV_INIT; st_next = ST_ADV_TEST; end
                    REQ_RESEED:  begin cmd.op = OP_SEED_INIT; st_next = ST_HASH; end
                    default:     st_next = ST_OUT;
                endcase
            end
            ST_STEP_WAIT:
            if (stat.mul_done)
            begin
                cmd.op = OP_STEP_DONE;
                st_next = ST_OUT;
            end
            ST_ADV_TEST:
            begin
                am_next = stat.delta_bit ? 3'd0 : 3'd2;
                st_next = stat.delta_zero ? ST_FIN_MUL : ST_ADV_MUL;
            end
            ST_ADV_MUL:
            begin
                cmd.op = OP_MUL_START;
                cmd.msel = (am_reg == 3'd0) ? MS_AM : (am_reg == 3'd1) ? MS_AP :
                           (am_reg == 3'd2) ? MS_CP : MS_CM;
                st_next = ST_ADV_WAIT;
            end
            ST_ADV_WAIT:
            if (stat.mul_done)
            begin
                cmd.op = (am_reg == 3'd0) ? OP_AM_DONE : (am_reg == 3'd1) ? OP_AP_DONE :
                         (am_reg == 3'd2) ? OP_CP_DONE : OP_CM_DONE;
                am_next = am_reg + 3'd1;
                st_next = (am_reg == 3'd3) ? ST_ADV_TEST : ST_ADV_MUL;
            end
            ST_FIN_MUL:
            begin
                cmd.op = OP_MUL_START;
                cmd.msel = MS_FINAL;
                st_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                cmd.msel = MS_FINAL;
                if (stat.mul_done)
                begin
                    cmd.op = OP_FINAL_DONE;
                    st_next = ST_OUT;
                end
            end
            ST_HASH:
            begin
                cmd.op = OP_HASH;
                seed2_next = 1'b0;
                if (stat.hash_done)
                    st_next = ST_SEED_MUL;
            end
            ST_SEED_MUL:
            begin
                cmd.op = OP_MUL_START;
                st_next = ST_SEED_WAIT;
            end
            ST_SEED_WAIT:
            if (stat.mul_done)
            begin
                cmd.op = OP_STEP_DONE;
                seed2_next = 1'b1;
                st_next = seed2_reg ? ST_OUT : ST_STEP_MUL;
            end
            ST_STEP_MUL:
            begin
                cmd.op = OP_ADD_INIT;
                st_next = ST_SEED_MUL;
            end
            ST_OUT:
            if (!(vld_reg && out_stall))
            begin
                vld_next = 1'b1;
                drw_next = (req_reg == REQ_DRAW);
                st_next  = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            req_reg   <= '0;
            am_reg    <= '0;
            seed2_reg <= 1'b0;
            vld_reg   <= 1'b0;
            drw_reg   <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            req_reg   <= req_next;
            am_reg    <= am_next;
            seed2_reg <= seed2_next;
            vld_reg   <= vld_next;
            drw_reg   <= drw_next;
        end
    end

    assign in_stall  = (st_reg != ST_IDLE) || (vld_reg && out_stall);
    assign out_valid = vld_reg;
    assign out_draw  = drw_reg;
endmodule

@@ hdl/pcg64_xsl_rr_generator_core.sv @@
// Top level of the PCG64 XSL-RR generator core.
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall| pcg_in_t
//  out     | output    | out_valid/out_stall | pcg_out_t
//  cfg     | input     | cfg_valid/cfg_ready | seed_value, 64 bits
// Draw: one LCG step using the 32x32 partial-product multiplier.
// Advance: cp, cm (plus am, ap if set) per distance bit, then a final product.
// Reseed: seed hash, LCG step, add init, LCG step; unused code: non-draw result.
// Next input transfer no earlier than the edge at which the result transfers.
// Reset clears state to 0, increment to 1, seed to 0. Result holds under stall.
module pcg64_xsl_rr_generator_core
    import pcg64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pcg_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output pcg_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    logic [63:0] seed_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        draw;
    logic [63:0] dval;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_valid)
            seed_reg <= cfg_data;
    end

    pcg64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req       (in_data.req_type),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_draw  (draw),
        .cmd       (cmd)
    );

    pcg64_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_item    (in_data),
        .seed       (seed_reg),
        .stat       (stat),
        .draw_value (dval)
    );

    // state does not move while a result is pending
    assign out_data.rand_value = draw ? dval : '0;
    assign out_data.is_draw    = draw;
endmodule
